// ===== sv/tdts_pkg.sv =====
// Shared types, constants and the LFSR step function of the tick-driven task scheduler.
`timescale 1ns / 1ps

package tdts_pkg;

  localparam int TASK_COUNT_DEF = 8;
  localparam int CNT_W          = 8;
  localparam int TASK_IDX_W     = 3;
  localparam int LFSR_W         = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_RESET = 16'h0001;

  // Input item codes.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 1'b1;

  // Policy codes.
  localparam logic POLICY_PRIO = 1'b0;
  localparam logic POLICY_SJF  = 1'b1;

  // One task table entry.
  typedef struct packed {
    logic [CNT_W-1:0] pri;
    logic [CNT_W-1:0] cnt;
  } word_t;

  // Controls from the sequencer to the task table.
  typedef struct packed {
    logic  we;
    logic  re;
    word_t wdata;
  } tbl_ctl_t;

  // Sequencer status toward the top level.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } sts_t;

  // One result word.
  typedef struct packed {
    logic [TASK_IDX_W-1:0] running_task;
    logic                  switched;
    logic [CNT_W-1:0]      running_counter;
    logic                  no_runnable;
  } res_t;

  // One step of the right-shifting Galois LFSR; a zero state counts as one.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] x;
    logic              lsb;
    x   = (v == '0) ? LFSR_RESET : v;
    lsb = x[0];
    x   = x >> 1;
    if (lsb) begin
      x = x ^ LFSR_TAPS;
    end
    return x;
  endfunction

endpackage

// ===== sv/tick_driven_task_scheduler_unit.sv =====
// Top level of the tick-driven task scheduler: configuration, handshakes, output register.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    func, task_index, counter_value, priority_value
//   out_     output     out_valid / out_stall  running_task, switched, running_counter,
//                                              no_runnable
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load word or a tick that does not reschedule goes straight to the result. A rescheduling
// tick scans the task table, and scans it again in a refill pass when no task is runnable;
// the task table has one read and one write port, and the scan takes one task per cycle.
// Reset is synchronous and clears the task table through per-entry valid bits at once.
// A result waits in the output register while out_stall is high; the next word is
// taken meanwhile and its result is held in the sequencer until the register frees.
`timescale 1ns / 1ps

module tick_driven_task_scheduler_unit #(
  parameter int TASK_COUNT = tdts_pkg::TASK_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [tdts_pkg::TASK_IDX_W-1:0]     in_task_index,
  input  logic [tdts_pkg::CNT_W-1:0]          in_counter_value,
  input  logic [tdts_pkg::CNT_W-1:0]          in_priority_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tdts_pkg::TASK_IDX_W-1:0]     out_running_task,
  output logic                                out_switched,
  output logic [tdts_pkg::CNT_W-1:0]          out_running_counter,
  output logic                                out_no_runnable,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tdts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tdts_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic              policy_mode_r, policy_mode_nxt;
  logic              seed_wr;
  logic              out_valid_r, out_valid_nxt;
  tdts_pkg::res_t    out_res_r;
  tdts_pkg::sts_t    sts;
  tdts_pkg::res_t    res;
  logic              res_ready;
  logic              in_go;

  assign cfg_ready = 1'b1;

  always_comb begin
    policy_mode_nxt = policy_mode_r;
    seed_wr         = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        tdts_pkg::CFG_POLICY_MODE: policy_mode_nxt = cfg_data[0];
        tdts_pkg::CFG_RANDOM_SEED: seed_wr = 1'b1;
        default: ;
      endcase
    end
  end

  assign in_go     = in_valid && sts.idle;
  assign in_stall  = !sts.idle;
  assign res_ready = !out_valid_r || !out_stall;

  tdts_ctrl #(.TASK_COUNT(TASK_COUNT)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .policy_mode    (policy_mode_r),
    .seed_wr        (seed_wr),
    .seed_val       (cfg_data[tdts_pkg::LFSR_W-1:0]),
    .in_go          (in_go),
    .func           (in_func),
    .task_index     (in_task_index),
    .counter_value  (in_counter_value),
    .priority_value (in_priority_value),
    .res_ready      (res_ready),
    .sts            (sts),
    .res            (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (sts.res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_mode_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      policy_mode_r <= policy_mode_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_running_task    = out_res_r.running_task;
  assign out_switched        = out_res_r.switched;
  assign out_running_counter = out_res_r.running_counter;
  assign out_no_runnable     = out_res_r.no_runnable;

endmodule

// ===== sv/tdts_table.sv =====
// Task table: counter and priority of every task in one synchronous memory.
`timescale 1ns / 1ps

module tdts_table #(
  parameter int TASK_COUNT = tdts_pkg::TASK_COUNT_DEF,
  localparam int AW = $clog2(TASK_COUNT)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tdts_pkg::tbl_ctl_t ctl,
  input  logic [AW-1:0]      waddr,
  input  logic [AW-1:0]      raddr,
  output tdts_pkg::word_t    rdata
);

  tdts_pkg::word_t           mem [TASK_COUNT];
  logic [TASK_COUNT-1:0]     vld_r;
  tdts_pkg::word_t           rd_word_r;
  logic                      rd_ok_r;

  // Entries never written read as zero counter and zero priority.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (ctl.we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (ctl.re) begin
        rd_ok_r <= vld_r[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rd_word_r <= mem[raddr];
    end
  end

  assign rdata = rd_ok_r ? rd_word_r : '0;

endmodule

// ===== sv/tdts_ctrl.sv =====
// Scheduler sequencer: load, tick decrement, selection scan and refill pass.
`timescale 1ns / 1ps

module tdts_ctrl #(
  parameter int TASK_COUNT = tdts_pkg::TASK_COUNT_DEF,
  localparam int AW = $clog2(TASK_COUNT)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                policy_mode,
  input  logic                                seed_wr,
  input  logic [tdts_pkg::LFSR_W-1:0]         seed_val,
  input  logic                                in_go,
  input  logic                                func,
  input  logic [tdts_pkg::TASK_IDX_W-1:0]     task_index,
  input  logic [tdts_pkg::CNT_W-1:0]          counter_value,
  input  logic [tdts_pkg::CNT_W-1:0]          priority_value,
  input  logic                                res_ready,
  output tdts_pkg::sts_t                      sts,
  output tdts_pkg::res_t                      res
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  localparam logic [AW:0]   RA_END   = (AW+1)'(TASK_COUNT);
  localparam logic [AW-1:0] IDX_LAST = AW'(TASK_COUNT - 1);

  state_t                          state_r, state_nxt;
  logic [AW-1:0]                   cur_r, cur_nxt;
  tdts_pkg::word_t                 cur_word_r, cur_word_nxt;
  logic [tdts_pkg::LFSR_W-1:0]     lfsr_r, lfsr_nxt;
  logic                            refill_r, refill_nxt;
  logic [AW:0]                     ra_r, ra_nxt;
  logic                            s_vld_r, s_vld_nxt;
  logic [AW-1:0]                   s_idx_r, s_idx_nxt;
  logic [AW-1:0]                   best_r, best_nxt;
  tdts_pkg::word_t                 best_word_r, best_word_nxt;
  tdts_pkg::res_t                  res_r, res_nxt;

  tdts_pkg::tbl_ctl_t              tbl_ctl;
  logic [AW-1:0]                   tbl_waddr;
  logic [AW-1:0]                   tbl_raddr;
  tdts_pkg::word_t                 tbl_rdata;

  logic                            load_ok;
  logic [AW-1:0]                   load_addr;
  logic [tdts_pkg::CNT_W-1:0]      dec_cnt;
  logic [tdts_pkg::LFSR_W-1:0]     lfsr_stepped;
  logic [tdts_pkg::CNT_W:0]        prio_sum;
  tdts_pkg::word_t                 stage_word;
  logic                            take;

  tdts_table #(.TASK_COUNT(TASK_COUNT)) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (tbl_ctl),
    .waddr (tbl_waddr),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign load_ok   = (task_index != '0) &&
                     ({{(32-tdts_pkg::TASK_IDX_W){1'b0}}, task_index} < TASK_COUNT);
  assign load_addr = AW'(task_index);
  assign dec_cnt   = (cur_word_r.cnt == '0) ? '0 : cur_word_r.cnt - 1'b1;
  assign lfsr_stepped = tdts_pkg::lfsr_step(lfsr_r);
  assign prio_sum  = {2'b00, tbl_rdata.cnt[tdts_pkg::CNT_W-1:1]} + {1'b0, tbl_rdata.pri};

  // The word seen by the selection stage: as read, or as rewritten by the refill.
  always_comb begin
    stage_word = tbl_rdata;
    if (refill_r) begin
      if (policy_mode == tdts_pkg::POLICY_PRIO) begin
        stage_word.cnt = prio_sum[tdts_pkg::CNT_W] ? '1 : prio_sum[tdts_pkg::CNT_W-1:0];
      end else begin
        stage_word.cnt = lfsr_stepped[tdts_pkg::CNT_W-1:0];
      end
    end
  end

  // Scanning upward, ties go to the later index for largest and to the earlier for smallest.
  always_comb begin
    if (stage_word.cnt == '0) begin
      take = 1'b0;
    end else if (best_r == '0) begin
      take = 1'b1;
    end else if (policy_mode == tdts_pkg::POLICY_PRIO) begin
      take = stage_word.cnt >= best_word_r.cnt;
    end else begin
      take = stage_word.cnt < best_word_r.cnt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cur_word_nxt  = cur_word_r;
    lfsr_nxt      = lfsr_r;
    refill_nxt    = refill_r;
    ra_nxt        = ra_r;
    s_vld_nxt     = 1'b0;
    s_idx_nxt     = s_idx_r;
    best_nxt      = best_r;
    best_word_nxt = best_word_r;
    res_nxt       = res_r;
    tbl_ctl       = '0;
    tbl_waddr     = '0;
    tbl_raddr     = ra_r[AW-1:0];

    if (seed_wr) begin
      lfsr_nxt = seed_val;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_go) begin
          res_nxt.running_task = tdts_pkg::TASK_IDX_W'(cur_r);
          res_nxt.switched     = 1'b0;
          res_nxt.no_runnable  = 1'b0;
          res_nxt.running_counter = cur_word_r.cnt;
          if (func == tdts_pkg::FUNC_LOAD) begin
            state_nxt = ST_DONE;
            if (load_ok) begin
              tbl_ctl.we        = 1'b1;
              tbl_ctl.wdata.cnt = counter_value;
              tbl_ctl.wdata.pri = priority_value;
              tbl_waddr         = load_addr;
              if (load_addr == cur_r) begin
                cur_word_nxt.cnt = counter_value;
                cur_word_nxt.pri = priority_value;
                res_nxt.running_counter = counter_value;
              end
            end
          end else begin
            if (cur_r != '0) begin
              tbl_ctl.we        = 1'b1;
              tbl_ctl.wdata.cnt = dec_cnt;
              tbl_ctl.wdata.pri = cur_word_r.pri;
              tbl_waddr         = cur_r;
              cur_word_nxt.cnt  = dec_cnt;
              res_nxt.running_counter = dec_cnt;
            end
            if (cur_r == '0 || dec_cnt == '0) begin
              state_nxt     = ST_SCAN;
              ra_nxt        = (AW+1)'(1);
              refill_nxt    = 1'b0;
              best_nxt      = '0;
              best_word_nxt = '0;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_SCAN: begin
        // Reads run one entry ahead of the selection stage.
        if (ra_r < RA_END) begin
          tbl_ctl.re = 1'b1;
          s_vld_nxt  = 1'b1;
          s_idx_nxt  = ra_r[AW-1:0];
          ra_nxt     = ra_r + 1'b1;
        end
        if (s_vld_r) begin
          if (refill_r) begin
            tbl_ctl.we    = 1'b1;
            tbl_ctl.wdata = stage_word;
            tbl_waddr     = s_idx_r;
            if (policy_mode == tdts_pkg::POLICY_SJF) begin
              lfsr_nxt = lfsr_stepped;
            end
          end
          if (take) begin
            best_nxt      = s_idx_r;
            best_word_nxt = stage_word;
          end
          if (s_idx_r == IDX_LAST) begin
            if (!refill_r && best_nxt == '0) begin
              refill_nxt = 1'b1;
              ra_nxt     = (AW+1)'(1);
            end else begin
              state_nxt                = ST_DONE;
              cur_nxt                  = best_nxt;
              cur_word_nxt             = best_word_nxt;
              res_nxt.running_task     = tdts_pkg::TASK_IDX_W'(best_nxt);
              res_nxt.switched         = best_nxt != cur_r;
              res_nxt.running_counter  = best_word_nxt.cnt;
              res_nxt.no_runnable      = best_nxt == '0;
            end
          end
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cur_r      <= '0;
      cur_word_r <= '0;
      lfsr_r     <= tdts_pkg::LFSR_RESET;
      refill_r   <= 1'b0;
      ra_r       <= '0;
      s_vld_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      cur_word_r <= cur_word_nxt;
      lfsr_r     <= lfsr_nxt;
      refill_r   <= refill_nxt;
      ra_r       <= ra_nxt;
      s_vld_r    <= s_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_idx_r     <= s_idx_nxt;
    best_r      <= best_nxt;
    best_word_r <= best_word_nxt;
    res_r       <= res_nxt;
  end

  assign sts.idle      = state_r == ST_IDLE;
  assign sts.res_valid = state_r == ST_DONE;
  assign res           = res_r;

endmodule
